// ----- hdl/asrc_pkg.sv -----
// ----------------------------------------------------------------------------
// asrc_pkg
// Shared types, codes and constants of the ARQ session rate controller.
// ----------------------------------------------------------------------------
package asrc_pkg;

    localparam int TX_BUFFER_BYTES_DEF = 65535;

    localparam int TIMEOUT_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int RETRY_W    = 4;
    localparam int LEVEL_W    = 4;
    localparam int LEN_W      = 12;
    localparam int REQ_W      = 3;
    localparam int PHASE_W    = 3;
    localparam int KIND_W     = 4;
    localparam int CODE_W     = 4;
    localparam int BYTES_W    = 7;
    localparam int SNR_W      = 5;
    localparam int RES_MAX    = 4;
    localparam int RES_IDX_W  = 2;
    localparam int RES_CNT_W  = 3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RETRY_TIMEOUT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RETRIES   = 1'b1;

    localparam logic [TIMEOUT_W-1:0] RETRY_TIMEOUT_RST = 16'd1000;
    localparam logic [RETRY_W-1:0]   MAX_RETRIES_RST   = 4'd5;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LISTEN     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CONNECT    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DISCONNECT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ABORT      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUEUE      = 3'd4;
    localparam logic [REQ_W-1:0] REQ_FRAME      = 3'd5;
    localparam logic [REQ_W-1:0] REQ_TICK       = 3'd6;

    // session phases
    localparam logic [PHASE_W-1:0] PH_DISC    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LISTEN  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CALL    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SEND    = 3'd3;
    localparam logic [PHASE_W-1:0] PH_RECV    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DISCING = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STATE     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_BURST     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_FRAME     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_CONNECTED = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DISCONN   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_SPEED     = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RETRY     = 4'd6;
    localparam logic [KIND_W-1:0] KIND_SNR       = 4'd7;
    localparam logic [KIND_W-1:0] KIND_DATA_RX   = 4'd8;

    // burst codes
    localparam logic [CODE_W-1:0] BURST_NACK = 4'd0;
    localparam logic [CODE_W-1:0] BURST_ACK  = 4'd1;
    localparam logic [CODE_W-1:0] BURST_QRT  = 4'd8;

    localparam logic [SNR_W-1:0] SNR_GOOD    = 5'd30;
    localparam logic [SNR_W-1:0] SNR_BAD     = 5'd10;
    localparam logic [SNR_W-1:0] SNR_TIMEOUT = 5'd0;

    localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 4'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 4'd14;
    localparam logic [LEVEL_W-1:0] LEVEL_SMALL = 4'd4;
    localparam logic [BYTES_W-1:0] BLOCK_SMALL = 7'd32;
    localparam logic [BYTES_W-1:0] BLOCK_LARGE = 7'd64;

    localparam logic [RETRY_W-1:0] RETRY_SAT = 4'd15;
    localparam logic [1:0]         ACK_SAT   = 2'd3;
    localparam logic [1:0]         ACK_STEP  = 2'd2;

    // one result beat, kind in the lowest bits
    typedef struct packed {
        logic [SNR_W-1:0]   snr_db;
        logic [RETRY_W-1:0] retry_count;
        logic [LEVEL_W-1:0] speed_level;
        logic [BYTES_W-1:0] frame_bytes;
        logic [CODE_W-1:0]  burst_code;
        logic               burst_positive;
        logic [PHASE_W-1:0] session_state;
        logic [KIND_W-1:0]  kind;
    } result_t;

    typedef struct packed {
        logic [PHASE_W-1:0]   phase;
        logic [LEVEL_W-1:0]   level;
        logic [1:0]           ack_run;
        logic [RETRY_W-1:0]   retries;
        logic                 timer_running;
        logic [TIMEOUT_W-1:0] timer_count;
    } sess_t;

    typedef struct packed {
        logic [RETRY_W-1:0]   max_retries;
        logic [TIMEOUT_W-1:0] retry_timeout;
    } cfg_t;

    function automatic result_t mk_res(
        input logic [KIND_W-1:0]  kind,
        input logic [PHASE_W-1:0] ph,
        input logic               pos,
        input logic [CODE_W-1:0]  code,
        input logic [BYTES_W-1:0] bytes,
        input logic [LEVEL_W-1:0] lv,
        input logic [RETRY_W-1:0] rt,
        input logic [SNR_W-1:0]   snr
    );
        result_t r;
        r.kind           = kind;
        r.session_state  = ph;
        r.burst_positive = pos;
        r.burst_code     = code;
        r.frame_bytes    = bytes;
        r.speed_level    = lv;
        r.retry_count    = rt;
        r.snr_db         = snr;
        return r;
    endfunction

endpackage

// ----- hdl/asrc_step.sv -----
// ----------------------------------------------------------------------------
// asrc_step
// Event logic: next session state and the result list for one request.
// ----------------------------------------------------------------------------
module asrc_step
    import asrc_pkg::*;
#(
    parameter int TX_BUFFER_BYTES = TX_BUFFER_BYTES_DEF,
    parameter int PEND_W          = $clog2(TX_BUFFER_BYTES + 1)
) (
    input  sess_t                  sess,
    input  logic [PEND_W-1:0]      pending,
    input  cfg_t                   cfg,
    input  logic [REQ_W-1:0]       req_type,
    input  logic [LEN_W-1:0]       data_len,
    input  logic                   frame_ok,
    output sess_t                  sess_next,
    output logic [PEND_W-1:0]      pending_next,
    output result_t                res [RES_MAX],
    output logic [RES_CNT_W-1:0]   res_cnt
);

    localparam int SUM_W = ((PEND_W > LEN_W) ? PEND_W : LEN_W) + 1;

    always_comb begin
        logic [PHASE_W-1:0]   ph;
        logic [LEVEL_W-1:0]   lv;
        logic [1:0]           ar;
        logic [RETRY_W-1:0]   rt;
        logic                 trun;
        logic [TIMEOUT_W-1:0] tcnt;
        logic [PEND_W-1:0]    pend;
        logic [RES_CNT_W-1:0] n;
        logic [SUM_W-1:0]     sum;
        logic [RETRY_W:0]     rt_inc;
        logic [BYTES_W-1:0]   blk;
        logic [BYTES_W-1:0]   nbytes;
        logic                 do_abort;
        logic                 do_send;
        logic                 do_adapt;
        logic                 adapt_ack;
        logic [SNR_W-1:0]     adapt_snr;

        ph   = sess.phase;
        lv   = sess.level;
        ar   = sess.ack_run;
        rt   = sess.retries;
        trun = sess.timer_running;
        tcnt = sess.timer_count;
        pend = pending;
        n    = '0;
        for (int i = 0; i < RES_MAX; i++) begin
            res[i] = '0;
        end
        sum       = SUM_W'(pending) + SUM_W'(data_len);
        rt_inc    = {1'b0, rt} + 1'b1;
        do_abort  = 1'b0;
        do_send   = 1'b0;
        do_adapt  = 1'b0;
        adapt_ack = 1'b0;
        adapt_snr = SNR_TIMEOUT;
        blk       = BLOCK_SMALL;
        nbytes    = '0;

        case (req_type)
            REQ_LISTEN: begin
                if (ph != PH_LISTEN) begin
                    ph = PH_LISTEN;
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_STATE, ph, 1'b0, '0, '0, lv, rt, '0);
                    n = n + 1'b1;
                end
            end
            REQ_CONNECT: begin
                if (ph != PH_CALL) begin
                    ph = PH_CALL;
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_STATE, ph, 1'b0, '0, '0, lv, rt, '0);
                    n = n + 1'b1;
                end
                res[n[RES_IDX_W-1:0]] = mk_res(KIND_BURST, ph, 1'b1, BURST_ACK, '0, lv, rt, '0);
                n = n + 1'b1;
                rt   = '0;
                trun = 1'b1;
                tcnt = cfg.retry_timeout;
            end
            REQ_DISCONNECT: begin
                if (ph != PH_DISCING) begin
                    ph = PH_DISCING;
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_STATE, ph, 1'b0, '0, '0, lv, rt, '0);
                    n = n + 1'b1;
                end
                res[n[RES_IDX_W-1:0]] = mk_res(KIND_BURST, ph, 1'b0, BURST_QRT, '0, lv, rt, '0);
                n = n + 1'b1;
                ph = PH_DISC;
                res[n[RES_IDX_W-1:0]] = mk_res(KIND_STATE, ph, 1'b0, '0, '0, lv, rt, '0);
                n = n + 1'b1;
                res[n[RES_IDX_W-1:0]] = mk_res(KIND_DISCONN, ph, 1'b0, '0, '0, lv, rt, '0);
                n = n + 1'b1;
            end
            REQ_ABORT: begin
                do_abort = 1'b1;
            end
            REQ_QUEUE: begin
                if (sum > SUM_W'(TX_BUFFER_BYTES)) begin
                    pend = PEND_W'(TX_BUFFER_BYTES);
                end else begin
                    pend = sum[PEND_W-1:0];
                end
                do_send = (ph == PH_SEND);
            end
            REQ_FRAME: begin
                trun = 1'b0;
                tcnt = '0;
                rt   = '0;
                if (ph == PH_CALL) begin
                    ph = PH_SEND;
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_STATE, ph, 1'b0, '0, '0, lv, rt, '0);
                    n = n + 1'b1;
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_CONNECTED, ph, 1'b0, '0, '0, lv, rt, '0);
                    n = n + 1'b1;
                    do_send = 1'b1;
                end else begin
                    do_adapt  = 1'b1;
                    adapt_ack = frame_ok;
                    adapt_snr = frame_ok ? SNR_GOOD : SNR_BAD;
                end
            end
            REQ_TICK: begin
                if (trun) begin
                    if (tcnt <= TIMEOUT_W'(1)) begin
                        trun = 1'b0;
                        tcnt = '0;
                        if (rt_inc > {1'b0, cfg.max_retries}) begin
                            rt = rt_inc[RETRY_W] ? RETRY_SAT : rt_inc[RETRY_W-1:0];
                            do_abort = 1'b1;
                        end else begin
                            rt = rt_inc[RETRY_W-1:0];
                            res[n[RES_IDX_W-1:0]] =
                                mk_res(KIND_RETRY, ph, 1'b0, '0, '0, lv, rt, '0);
                            n = n + 1'b1;
                            do_adapt  = 1'b1;
                            adapt_ack = 1'b0;
                            adapt_snr = SNR_TIMEOUT;
                        end
                    end else begin
                        tcnt = tcnt - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (do_adapt) begin
            res[n[RES_IDX_W-1:0]] = mk_res(KIND_SNR, ph, 1'b0, '0, '0, lv, rt, adapt_snr);
            n = n + 1'b1;
            if (adapt_ack) begin
                if (ar < ACK_SAT) begin
                    ar = ar + 1'b1;
                end
                if (ar >= ACK_STEP && lv < LEVEL_MAX) begin
                    lv = lv + 1'b1;
                    ar = '0;
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_SPEED, ph, 1'b0, '0, '0, lv, rt, '0);
                    n = n + 1'b1;
                end
            end else begin
                ar = '0;
                if (lv > LEVEL_MIN) begin
                    lv = lv - 1'b1;
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_SPEED, ph, 1'b0, '0, '0, lv, rt, '0);
                    n = n + 1'b1;
                end
            end
            if (req_type == REQ_FRAME) begin
                if (frame_ok) begin
                    res[n[RES_IDX_W-1:0]] =
                        mk_res(KIND_DATA_RX, ph, 1'b0, '0, '0, lv, rt, '0);
                    n = n + 1'b1;
                end
                if (ph == PH_RECV) begin
                    res[n[RES_IDX_W-1:0]] = mk_res(KIND_BURST, ph, frame_ok,
                        frame_ok ? BURST_ACK : BURST_NACK, '0, lv, rt, '0);
                    n = n + 1'b1;
                end
            end else if (ph == PH_SEND) begin
                do_send = 1'b1;
            end else if (ph == PH_CALL) begin
                res[n[RES_IDX_W-1:0]] = mk_res(KIND_BURST, ph, 1'b1, BURST_ACK, '0, lv, rt, '0);
                n = n + 1'b1;
                trun = 1'b1;
                tcnt = cfg.retry_timeout;
            end
        end

        if (do_send && pend != '0) begin
            blk = (lv <= LEVEL_SMALL) ? BLOCK_SMALL : BLOCK_LARGE;
            if (SUM_W'(pend) < SUM_W'(blk)) begin
                nbytes = BYTES_W'(pend);
            end else begin
                nbytes = blk;
            end
            res[n[RES_IDX_W-1:0]] = mk_res(KIND_FRAME, ph, 1'b0, '0, nbytes, lv, rt, '0);
            n = n + 1'b1;
            trun = 1'b1;
            tcnt = cfg.retry_timeout;
        end

        if (do_abort) begin
            trun = 1'b0;
            tcnt = '0;
            pend = '0;
            if (ph != PH_DISC) begin
                ph = PH_DISC;
                res[n[RES_IDX_W-1:0]] = mk_res(KIND_STATE, ph, 1'b0, '0, '0, lv, rt, '0);
                n = n + 1'b1;
            end
            res[n[RES_IDX_W-1:0]] = mk_res(KIND_DISCONN, ph, 1'b0, '0, '0, lv, rt, '0);
            n = n + 1'b1;
        end

        sess_next.phase         = ph;
        sess_next.level         = lv;
        sess_next.ack_run       = ar;
        sess_next.retries       = rt;
        sess_next.timer_running = trun;
        sess_next.timer_count   = tcnt;
        pending_next            = pend;
        res_cnt                 = n;
    end

endmodule

// ----- hdl/asrc_outq.sv -----
// ----------------------------------------------------------------------------
// asrc_outq
// Result buffer: holds the results of one request and sends them in order.
// ----------------------------------------------------------------------------
module asrc_outq
    import asrc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  result_t              load_res [RES_MAX],
    input  logic [RES_CNT_W-1:0] load_cnt,
    output logic                 free,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output result_t              m_res,
    output logic                 m_tlast
);

    result_t              buf_reg [RES_MAX];
    logic [RES_CNT_W-1:0] cnt_reg;
    logic [RES_CNT_W-1:0] idx_reg;
    logic                 pop;

    assign m_tvalid = (cnt_reg != '0);
    assign m_res    = buf_reg[idx_reg[RES_IDX_W-1:0]];
    assign m_tlast  = ((idx_reg + 1'b1) == cnt_reg);
    assign pop      = m_tvalid && m_tready;
    assign free     = !m_tvalid || (pop && m_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (load) begin
            cnt_reg <= load_cnt;
            idx_reg <= '0;
        end else if (pop) begin
            if (m_tlast) begin
                cnt_reg <= '0;
                idx_reg <= '0;
            end else begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= load_res;
        end
    end

endmodule

// ----- hdl/arq_session_rate_controller_unit.sv -----
// ----------------------------------------------------------------------------
// arq_session_rate_controller_unit
// ARQ session controller with retry timer, retry count and speed adaptation.
//
//   channel  | direction | width      | contents
//   s_*      | in        | 16 + 3     | request beat, request type in tuser
//   m_*      | out       | 32 + 4 + 1 | result beats, kind in tuser, tlast on the final one
//   cfg_*    | in        | 16         | register writes, index 0 timeout, 1 max retries
//
// a request is evaluated while it waits in the input register; once the result
// buffer is free, its 0 to 4 results are loaded into the result buffer
// the buffer sends one result beat per cycle while m_tready is high, so a request
// holds the output until its 0 to 4 beats are taken, and the next request is
// evaluated as the last beat leaves; results pass the input register, then the buffer
// reset is synchronous and active low, resets session state, buffer and registers
// a stalled output holds the buffer; the input register still takes one beat
// ----------------------------------------------------------------------------
module arq_session_rate_controller_unit
    import asrc_pkg::*;
#(
    parameter int TX_BUFFER_BYTES = TX_BUFFER_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // data_len[11:0] frame_ok[12]
    input  logic [REQ_W-1:0]      s_tuser,   // req_type[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // session_state[2:0] burst_positive[3]
                                             // burst_code[7:4] frame_bytes[14:8]
                                             // speed_level[18:15] retry_count[22:19]
                                             // snr_db[27:23]
    output logic [KIND_W-1:0]     m_tuser,   // kind[3:0]
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PEND_W = $clog2(TX_BUFFER_BYTES + 1);

    logic                 in_valid_reg;
    logic [REQ_W-1:0]     req_type_reg;
    logic [LEN_W-1:0]     data_len_reg;
    logic                 frame_ok_reg;

    sess_t                sess_reg;
    sess_t                sess_next;
    logic [PEND_W-1:0]    pending_reg;
    logic [PEND_W-1:0]    pending_next;
    cfg_t                 cfg_reg;

    result_t              step_res [RES_MAX];
    logic [RES_CNT_W-1:0] step_cnt;
    result_t              out_res;
    logic                 q_free;
    logic                 fire;

    assign fire     = in_valid_reg && q_free;
    assign s_tready = !in_valid_reg || fire;
    assign m_tuser  = out_res.kind;
    assign m_tdata  = {4'b0000, out_res.snr_db, out_res.retry_count, out_res.speed_level,
                       out_res.frame_bytes, out_res.burst_code, out_res.burst_positive,
                       out_res.session_state};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_type_reg <= s_tuser;
            data_len_reg <= s_tdata[11:0];
            frame_ok_reg <= s_tdata[12];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sess_reg.phase         <= PH_DISC;
            sess_reg.level         <= LEVEL_MIN;
            sess_reg.ack_run       <= '0;
            sess_reg.retries       <= '0;
            sess_reg.timer_running <= 1'b0;
            sess_reg.timer_count   <= '0;
            pending_reg            <= '0;
        end else if (fire) begin
            sess_reg    <= sess_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retry_timeout <= RETRY_TIMEOUT_RST;
            cfg_reg.max_retries   <= MAX_RETRIES_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RETRY_TIMEOUT: cfg_reg.retry_timeout <= cfg_wdata[TIMEOUT_W-1:0];
                REG_MAX_RETRIES:   cfg_reg.max_retries   <= cfg_wdata[RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    asrc_step #(
        .TX_BUFFER_BYTES (TX_BUFFER_BYTES),
        .PEND_W          (PEND_W)
    ) u_step (
        .sess         (sess_reg),
        .pending      (pending_reg),
        .cfg          (cfg_reg),
        .req_type     (req_type_reg),
        .data_len     (data_len_reg),
        .frame_ok     (frame_ok_reg),
        .sess_next    (sess_next),
        .pending_next (pending_next),
        .res          (step_res),
        .res_cnt      (step_cnt)
    );

    asrc_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .load_res (step_res),
        .load_cnt (step_cnt),
        .free     (q_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (out_res),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/asrc_checker.sv -----
// ----------------------------------------------------------------------------
// asrc_checker
// Port-level checks of the session controller, bound to the top level.
// ----------------------------------------------------------------------------
module asrc_checker
    import asrc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [31:0]       m_tdata,
    input logic [KIND_W-1:0] m_tuser,
    input logic              m_tlast
);

    result_t r;
    assign r = {m_tdata[27:0], m_tuser};

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
            $stable(m_tlast))
        else $error("stalled result beat changed");

    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> r.speed_level >= LEVEL_MIN && r.speed_level <= LEVEL_MAX)
        else $error("speed level out of range");

    a_snr_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.kind != KIND_SNR |-> r.snr_db == '0)
        else $error("snr on a non-snr result");

    a_frame_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.kind == KIND_FRAME |->
            r.frame_bytes != '0 && r.frame_bytes <= BLOCK_LARGE &&
            (r.speed_level > LEVEL_SMALL || r.frame_bytes <= BLOCK_SMALL))
        else $error("frame size does not match speed level");

endmodule

bind arq_session_rate_controller_unit asrc_checker u_asrc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
);
